// ===== sv/gpec_pkg.sv =====
// ----------------------------------------------------------------------------
// gpec_pkg
// shared constants and types of the glyph pixel expander
// ----------------------------------------------------------------------------
package gpec_pkg;

   localparam int GLYPH_WIDTH  = 8;
   localparam int GLYPH_HEIGHT = 8;
   localparam int GLYPH_COUNT  = 128;

   localparam int CODE_W = $clog2(GLYPH_COUNT);
   localparam int COL_W  = $clog2(GLYPH_WIDTH);
   localparam int ROW_W  = $clog2(GLYPH_HEIGHT);

   localparam int FONT_DEPTH = 1024;
   localparam int FONT_AW    = 10;
   localparam int FONT_DW    = 8;

   localparam int CHAR_W   = 8;
   localparam int COORD_W  = 13;
   localparam int PIX_W    = 14;
   localparam int COLOR_W  = 32;
   localparam int SCREEN_W = 13;

   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   localparam logic [SCREEN_W-1:0] SCREEN_WIDTH_RESET  = SCREEN_W'(1024);
   localparam logic [SCREEN_W-1:0] SCREEN_HEIGHT_RESET = SCREEN_W'(768);

   typedef enum logic {
      CMD_DRAW       = 1'b0,
      CMD_FONT_WRITE = 1'b1
   } cmd_type;

   typedef enum logic {
      REG_SCREEN_WIDTH  = 1'b0,
      REG_SCREEN_HEIGHT = 1'b1
   } csr_reg_type;

endpackage

// ===== sv/gpec_req_if.sv =====
// ----------------------------------------------------------------------------
// gpec_req_if
// command channel: draw a character or write one font row
// ----------------------------------------------------------------------------
interface gpec_req_if;
   import gpec_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      command;
   logic [CHAR_W-1:0]         char_code;
   logic signed [COORD_W-1:0] origin_x;
   logic signed [COORD_W-1:0] origin_y;
   logic [COLOR_W-1:0]        fg_color;
   logic [COLOR_W-1:0]        bg_color;
   logic [FONT_AW-1:0]        font_address;
   logic [FONT_DW-1:0]        font_data;

   modport source (
      output valid, command, char_code, origin_x, origin_y, fg_color, bg_color,
             font_address, font_data,
      input  ready
   );

   modport sink (
      input  valid, command, char_code, origin_x, origin_y, fg_color, bg_color,
             font_address, font_data,
      output ready
   );

endinterface

// ===== sv/gpec_rsp_if.sv =====
// ----------------------------------------------------------------------------
// gpec_rsp_if
// pixel channel: one beat per glyph pixel
// ----------------------------------------------------------------------------
interface gpec_rsp_if;
   import gpec_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [PIX_W-1:0] pixel_x;
   logic signed [PIX_W-1:0] pixel_y;
   logic [COLOR_W-1:0]      pixel_color;
   logic                    visible;
   logic                    last;

   modport source (
      output valid, pixel_x, pixel_y, pixel_color, visible, last,
      input  ready
   );

   modport sink (
      input  valid, pixel_x, pixel_y, pixel_color, visible, last,
      output ready
   );

endinterface

// ===== sv/gpec_ram.sv =====
// ----------------------------------------------------------------------------
// gpec_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module gpec_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/glyph_pixel_expander_clip.sv =====
// ----------------------------------------------------------------------------
// glyph_pixel_expander_clip
// 8x8 bitmap font character generator with screen clipping
//
//   port   | dir  | role
//   -------+------+-----------------------------------------------
//   req    | in   | draw command or font row write, one per beat
//   rsp    | out  | pixel beat: coordinate, color, visible, last
//   apb    | in   | screen width at 0x0, screen height at 0x4
//
// a draw beat issues 64 pixels, one per cycle unless rsp stalls, columns
// outer and rows inner; the next beat is taken in the cycle the last pixel
// issues. pixels reach rsp through the font ram read, coordinate and color,
// and clip compare stages. reset clears the sequencer and valid bits, sets
// the screen size to 1024 by 768; the font ram is undefined until written.
// a stall on rsp freezes every stage and the ram read in place.
// ----------------------------------------------------------------------------
module glyph_pixel_expander_clip (
   input  logic                        clock,
   input  logic                        reset,
   gpec_req_if.sink                    req,
   gpec_rsp_if.source                  rsp,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [gpec_pkg::CSR_AW-1:0] paddr,
   input  logic [gpec_pkg::CSR_DW-1:0] pwdata,
   output logic [gpec_pkg::CSR_DW-1:0] prdata,
   output logic                        pready
);
   import gpec_pkg::*;

   logic                adv;
   logic                last_pix;
   logic                accept;
   logic                draw_go;
   logic                font_wr;
   logic                csr_wr;

   logic [SCREEN_W-1:0] width_ff, width_in;
   logic [SCREEN_W-1:0] height_ff, height_in;

   logic                busy_ff, busy_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [ROW_W-1:0]    row_ff, row_in;

   logic [CODE_W-1:0]         code_ff;
   logic signed [COORD_W-1:0] ox_ff;
   logic signed [COORD_W-1:0] oy_ff;
   logic [COLOR_W-1:0]        fg_ff;
   logic [COLOR_W-1:0]        bg_ff;

   logic [FONT_AW-1:0]  rd_addr;
   logic [FONT_DW-1:0]  rd_data;

   logic                      s1_valid_ff;
   logic [COL_W-1:0]          s1_col_ff;
   logic [ROW_W-1:0]          s1_row_ff;
   logic signed [COORD_W-1:0] s1_ox_ff;
   logic signed [COORD_W-1:0] s1_oy_ff;
   logic [COLOR_W-1:0]        s1_fg_ff;
   logic [COLOR_W-1:0]        s1_bg_ff;
   logic                      s1_last_ff;

   logic                      s2_valid_ff;
   logic signed [PIX_W-1:0]   s2_px_ff, s2_px_in;
   logic signed [PIX_W-1:0]   s2_py_ff, s2_py_in;
   logic [COLOR_W-1:0]        s2_color_ff, s2_color_in;
   logic                      s2_last_ff;

   logic                      out_valid_ff;
   logic signed [PIX_W-1:0]   out_px_ff;
   logic signed [PIX_W-1:0]   out_py_ff;
   logic [COLOR_W-1:0]        out_color_ff;
   logic                      out_vis_ff, out_vis_in;
   logic                      out_last_ff;

   // handshake
   assign adv      = !out_valid_ff || rsp.ready;
   assign last_pix = (col_ff == COL_W'(GLYPH_WIDTH - 1)) &&
                     (row_ff == ROW_W'(GLYPH_HEIGHT - 1));
   assign req.ready = adv && (!busy_ff || last_pix);
   assign accept    = req.valid && req.ready;
   assign draw_go   = accept && (cmd_type'(req.command) == CMD_DRAW);
   assign font_wr   = accept && (cmd_type'(req.command) == CMD_FONT_WRITE);

   // screen size registers
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_wr) begin
         unique case (csr_reg_type'(paddr[2]))
            REG_SCREEN_WIDTH:  width_in  = pwdata[SCREEN_W-1:0];
            REG_SCREEN_HEIGHT: height_in = pwdata[SCREEN_W-1:0];
            default:           width_in  = width_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_reg_type'(paddr[2]))
         REG_SCREEN_WIDTH:  prdata = CSR_DW'(width_ff);
         REG_SCREEN_HEIGHT: prdata = CSR_DW'(height_ff);
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SCREEN_WIDTH_RESET;
         height_ff <= SCREEN_HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // pixel sequencer
   always_comb begin
      busy_in = busy_ff;
      col_in  = col_ff;
      row_in  = row_ff;
      if (adv && busy_ff) begin
         if (last_pix) begin
            busy_in = 1'b0;
            col_in  = '0;
            row_in  = '0;
         end else if (row_ff == ROW_W'(GLYPH_HEIGHT - 1)) begin
            row_in = '0;
            col_in = col_ff + COL_W'(1);
         end else begin
            row_in = row_ff + ROW_W'(1);
         end
      end
      if (draw_go) begin
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         col_ff  <= '0;
         row_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         col_ff  <= col_in;
         row_ff  <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (draw_go) begin
         code_ff <= req.char_code[CODE_W-1:0];
         ox_ff   <= req.origin_x;
         oy_ff   <= req.origin_y;
         fg_ff   <= req.fg_color;
         bg_ff   <= req.bg_color;
      end
   end

   // font store
   assign rd_addr = FONT_AW'(int'(code_ff) * GLYPH_HEIGHT + int'(row_ff));

   gpec_ram #(
      .WIDTH (FONT_DW),
      .DEPTH (FONT_DEPTH)
   ) u_font_ram (
      .clock   (clock),
      .wr_en   (font_wr),
      .wr_addr (req.font_address),
      .wr_data (req.font_data),
      .rd_en   (adv),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // stage 2: coordinate and color
   always_comb begin
      s2_px_in    = {s1_ox_ff[COORD_W-1], s1_ox_ff} + PIX_W'(s1_col_ff);
      s2_py_in    = {s1_oy_ff[COORD_W-1], s1_oy_ff} + PIX_W'(s1_row_ff);
      s2_color_in = rd_data[s1_col_ff] ? s1_fg_ff : s1_bg_ff;
   end

   // stage 3: clip
   always_comb begin
      out_vis_in = !s2_px_ff[PIX_W-1] && (s2_px_ff[PIX_W-2:0] < width_ff) &&
                   !s2_py_ff[PIX_W-1] && (s2_py_ff[PIX_W-2:0] < height_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= busy_ff;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_col_ff    <= col_ff;
         s1_row_ff    <= row_ff;
         s1_ox_ff     <= ox_ff;
         s1_oy_ff     <= oy_ff;
         s1_fg_ff     <= fg_ff;
         s1_bg_ff     <= bg_ff;
         s1_last_ff   <= last_pix;
         s2_px_ff     <= s2_px_in;
         s2_py_ff     <= s2_py_in;
         s2_color_ff  <= s2_color_in;
         s2_last_ff   <= s1_last_ff;
         out_px_ff    <= s2_px_ff;
         out_py_ff    <= s2_py_ff;
         out_color_ff <= s2_color_ff;
         out_vis_ff   <= out_vis_in;
         out_last_ff  <= s2_last_ff;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.pixel_x     = out_px_ff;
   assign rsp.pixel_y     = out_py_ff;
   assign rsp.pixel_color = out_color_ff;
   assign rsp.visible     = out_vis_ff;
   assign rsp.last        = out_last_ff;

endmodule
